/* sv/dssu_pkg.sv */
`default_nettype none

package dssu_pkg;

  // field widths
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned TICK_W  = 6;
  localparam int unsigned CFG_W   = 2;

  // reset values of the registers and state
  localparam logic [SPEED_W-1:0] FLOOR_RST        = 8'd0;
  localparam logic [SPEED_W-1:0] CEILING_RST      = 8'd255;
  localparam logic [SPEED_W-1:0] INITIAL_RST      = 8'd0;
  localparam logic [CNT_W-1:0]   RELOAD_RST       = 8'd5;
  localparam logic               RED_RST          = 1'b1;

  // blink bit of the tick counter
  localparam int unsigned BLINK_BIT = 5;

  // configuration register indexes
  typedef enum logic [CFG_W-1:0] {
    CFG_FLOOR           = 2'd0,
    CFG_CEILING         = 2'd1,
    CFG_INITIAL_DRIVE   = 2'd2,
    CFG_DEBOUNCE_RELOAD = 2'd3
  } cfg_idx_t;

  // debounced button events for the setpoint logic
  typedef struct packed {
    logic up_press;
    logic down_press;
    logic set_mode;
  } btn_evt_t;

endpackage

`default_nettype wire

/* sv/debounced_speed_setpoint_unit.sv */
`default_nettype none

// Debounced speed setpoint: each input beat is one poll tick with the raw up,
// down and set-enable levels; each tick gives exactly one result beat with the
// drive value, both LEDs and the debounced set mode. The unit takes one tick
// per clock cycle while the result side does not stall. A tick sits in the
// input register and moves into the result register once that register is
// free; the debouncers and the setpoint state step at that same edge. Stall on
// the result side holds both registers and then stalls the input.
// Configuration writes are always ready; write them only while no tick is in
// flight. Writing the initial drive register also loads the current drive
// value.
module debounced_speed_setpoint_unit
  import dssu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // tick input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_raw_up,
  input  wire logic               in_raw_down,
  input  wire logic               in_raw_enable,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [SPEED_W-1:0]      out_drive_value,
  output logic                    out_green_led,
  output logic                    out_red_led,
  output logic                    out_set_mode,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_index,
  input  wire logic [SPEED_W-1:0] cfg_data
);

  logic               s1_valid_r;
  logic               s1_up_r;
  logic               s1_down_r;
  logic               s1_en_r;
  logic               out_valid_r;
  logic [SPEED_W-1:0] out_drive_r;
  logic               out_green_r;
  logic               out_red_r;
  logic               out_mode_r;

  logic [SPEED_W-1:0] floor_r;
  logic [SPEED_W-1:0] ceil_r;
  logic [CNT_W-1:0]   reload_r;

  logic               cfg_wr;
  logic               init_load;
  logic               out_free;
  logic               adv;
  logic               in_take;
  btn_evt_t           evt;
  logic               up_lvl;
  logic               up_chg;
  logic               dn_lvl;
  logic               dn_chg;
  logic               en_lvl;
  logic               en_chg;
  logic [SPEED_W-1:0] drive_nxt;
  logic               green_nxt;
  logic               red_nxt;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration register decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r  <= FLOOR_RST;
      ceil_r   <= CEILING_RST;
      reload_r <= RELOAD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FLOOR:           floor_r  <= cfg_data;
        CFG_CEILING:         ceil_r   <= cfg_data;
        CFG_INITIAL_DRIVE:   ;
        CFG_DEBOUNCE_RELOAD: reload_r <= cfg_data;
        default:             ;
      endcase
    end
  end

  assign init_load = cfg_wr && (cfg_idx_t'(cfg_index) == CFG_INITIAL_DRIVE);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_up_r   <= in_raw_up;
      s1_down_r <= in_raw_down;
      s1_en_r   <= in_raw_enable;
    end
  end

  // debouncers
  dssu_debounce u_deb_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .sample    (s1_up_r),
    .reload    (reload_r),
    .level_nxt (up_lvl),
    .changed   (up_chg)
  );

  dssu_debounce u_deb_down (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .sample    (s1_down_r),
    .reload    (reload_r),
    .level_nxt (dn_lvl),
    .changed   (dn_chg)
  );

  dssu_debounce u_deb_en (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .sample    (s1_en_r),
    .reload    (reload_r),
    .level_nxt (en_lvl),
    .changed   (en_chg)
  );

  // press events: fresh change to the pressed level; set mode follows the enable level
  always_comb begin
    evt.up_press   = up_chg && up_lvl;
    evt.down_press = dn_chg && dn_lvl;
    evt.set_mode   = en_lvl || (en_chg && en_lvl);
  end

  // drive setpoint and leds
  dssu_setpoint u_setpoint (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .evt        (evt),
    .floor_val  (floor_r),
    .ceil_val   (ceil_r),
    .init_load  (init_load),
    .init_value (cfg_data),
    .drive_nxt  (drive_nxt),
    .green_nxt  (green_nxt),
    .red_nxt    (red_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_drive_r <= drive_nxt;
      out_green_r <= green_nxt;
      out_red_r   <= red_nxt;
      out_mode_r  <= evt.set_mode;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_r;
  assign out_green_led   = out_green_r;
  assign out_red_led     = out_red_r;
  assign out_set_mode    = out_mode_r;

`ifndef NO_ASSERTIONS
  // the input only stalls while a tick sits in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // a tick leaving the input register shows up as a result next cycle
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("advanced tick produced no result");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_valid_r))
    else $error("pipeline not empty after reset");

  // a held result is never overwritten by a new tick
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !adv)
    else $error("result register loaded while stalled");
`endif

endmodule

`default_nettype wire

/* sv/dssu_debounce.sv */
`default_nettype none

module dssu_debounce
  import dssu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             sample,
  input  wire logic [CNT_W-1:0] reload,
  output logic                  level_nxt,
  output logic                  changed
);

  logic             level_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // counter debouncer: reload on match, count down on mismatch, take level at zero
  always_comb begin
    level_nxt = level_r;
    changed   = 1'b0;
    if (sample == level_r) begin
      cnt_nxt = reload;
    end else if (cnt_r == '0) begin
      level_nxt = sample;
      changed   = 1'b1;
      cnt_nxt   = reload;
    end else begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // state update on each tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      cnt_r   <= '0;
    end else if (adv) begin
      level_r <= level_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/dssu_setpoint.sv */
`default_nettype none

module dssu_setpoint
  import dssu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire btn_evt_t           evt,
  input  wire logic [SPEED_W-1:0] floor_val,
  input  wire logic [SPEED_W-1:0] ceil_val,
  input  wire logic               init_load,
  input  wire logic [SPEED_W-1:0] init_value,
  output logic [SPEED_W-1:0]      drive_nxt,
  output logic                    green_nxt,
  output logic                    red_nxt
);

  logic [SPEED_W-1:0] drive_r;
  logic [TICK_W-1:0]  tick_r;
  logic [TICK_W-1:0]  tick_nxt;
  logic               green_r;
  logic               red_r;
  logic [SPEED_W-1:0] drive_dn;
  logic [SPEED_W-1:0] drive_up;

  // in set mode: down first, then up, each one step toward its limit
  always_comb begin
    tick_nxt = tick_r + 1'b1;
    drive_dn = (evt.down_press && (drive_r > floor_val)) ? drive_r - 1'b1 : drive_r;
    drive_up = (evt.up_press && (drive_dn < ceil_val)) ? drive_dn + 1'b1 : drive_dn;
    drive_nxt = drive_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    if (evt.set_mode) begin
      drive_nxt = drive_up;
      green_nxt = tick_nxt[BLINK_BIT];
      red_nxt   = (drive_up == floor_val) || (drive_up == ceil_val);
    end
  end

  // setpoint state, loaded from the initial drive register on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= INITIAL_RST;
      tick_r  <= '0;
      green_r <= 1'b0;
      red_r   <= RED_RST;
    end else begin
      if (adv) begin
        drive_r <= drive_nxt;
        tick_r  <= tick_nxt;
        green_r <= green_nxt;
        red_r   <= red_nxt;
      end
      if (init_load) begin
        drive_r <= init_value;
      end
    end
  end

endmodule

`default_nettype wire
